/* rtl/core/tld_pkg.sv */
// Shared types and constants of the text load decoder.
`timescale 1ns / 1ps

package tld_pkg;

   // Field widths.
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 24;
   localparam int CODE_W      = 21;
   localparam int RSP_FIELD_W = 37;
   localparam int RSP_DATA_W  = 40;

   // Default size limit of one file, in bytes.
   localparam int unsigned MAX_FILE_BYTES_DEF = 32'd8388608;

   // Byte-order mark and line-ending characters.
   localparam logic [BYTE_W-1:0] MARK_B0 = 8'hEF;
   localparam logic [BYTE_W-1:0] MARK_B1 = 8'hBB;
   localparam logic [BYTE_W-1:0] MARK_B2 = 8'hBF;
   localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;

   // UTF-8 lead and continuation byte patterns.
   localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;
   localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
   localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;

   // Code point limits.
   localparam logic [CODE_W-1:0] CODE_MAX  = 21'h10FFFF;
   localparam logic [CODE_W-1:0] SURR_LO   = 21'h00D800;
   localparam logic [CODE_W-1:0] SURR_HI   = 21'h00DFFF;
   localparam logic [CODE_W-1:0] MIN_TWO   = 21'h000080;
   localparam logic [CODE_W-1:0] MIN_THREE = 21'h000800;
   localparam logic [CODE_W-1:0] MIN_FOUR  = 21'h010000;

   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

   typedef enum logic {
      KIND_TEXT,
      KIND_SUMMARY
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_INVALID,
      STATUS_TOO_LARGE
   } status_type;

   typedef enum logic [1:0] {
      EOL_LF,
      EOL_CRLF,
      EOL_CR,
      EOL_MIXED
   } eol_type;

   // One step of work handed from the input stage to the body checker.
   typedef struct packed {
      logic              valid;
      logic              summary;
      logic [BYTE_W-1:0] data;
      logic              mark;
      logic              oversize;
      logic              run_end;
   } op_type;

endpackage

/* rtl/core/tld_body.sv */
// UTF-8 checker, line-ending normalizer and result register of the decoder.
`timescale 1ns / 1ps

module tld_body
   import tld_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  op_type                op_in,
   output logic                  op_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rsp_tdata: text_byte[7:0], status[9:8], eol_kind[11:10], had_mark[12],
   // text_length[36:13], zero fill[39:37]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: item_kind[0]
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   typedef enum logic [1:0] {
      CLASS_NONE,
      CLASS_TWO,
      CLASS_THREE,
      CLASS_FOUR
   } class_type;

   // Body state.
   logic [1:0]        need_ff, need_in;
   logic [CODE_W-1:0] accum_ff, accum_in;
   class_type         class_ff, class_in;
   logic              bad_ff, bad_in;
   logic              cr_ff, cr_in;
   logic [2:0]        flags_ff, flags_in;
   logic [LEN_W-1:0]  count_ff, count_in;

   // Result register.
   logic              out_valid_ff;
   kind_type          out_kind_ff, out_kind_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_last_ff;
   status_type        out_status_ff, out_status_in;
   eol_type           out_eol_ff, out_eol_in;
   logic              out_mark_ff, out_mark_in;
   logic [LEN_W-1:0]  out_len_ff, out_len_in;

   logic              fire;
   logic              out_load;
   logic [BYTE_W-1:0] b;
   logic [CODE_W-1:0] code_new;
   logic [CODE_W-1:0] code_low;
   logic              drop;
   logic [2:0]        fin_flags;
   logic              fin_bad;

   assign op_ready = !out_valid_ff || rsp_tready;
   assign fire     = op_in.valid && op_ready;
   assign b        = op_in.data;
   assign code_new = {accum_ff[CODE_W-7:0], b[5:0]};

   // Lower bound of the code point for the current sequence length.
   always_comb begin
      case (class_ff)
         CLASS_TWO:   code_low = MIN_TWO;
         CLASS_THREE: code_low = MIN_THREE;
         default:     code_low = MIN_FOUR;
      endcase
   end

   // One step of work: either one body byte or the closing summary.
   always_comb begin
      need_in       = need_ff;
      accum_in      = accum_ff;
      class_in      = class_ff;
      bad_in        = bad_ff;
      cr_in         = cr_ff;
      flags_in      = flags_ff;
      count_in      = count_ff;
      out_load      = 1'b0;
      out_kind_in   = KIND_TEXT;
      out_byte_in   = b;
      out_status_in = STATUS_OK;
      out_eol_in    = EOL_LF;
      out_mark_in   = 1'b0;
      out_len_in    = '0;
      drop          = 1'b0;
      fin_flags     = flags_ff | {cr_ff, 2'b00};
      fin_bad       = bad_ff || (need_ff != 2'd0);

      if (fire && !op_in.summary) begin
         // UTF-8 decoding and validity checks.
         if (need_ff == 2'd0) begin
            if (!b[7]) begin
               if (b == CHAR_NUL) begin
                  bad_in = 1'b1;
               end
            end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
               need_in  = 2'd1;
               class_in = CLASS_TWO;
               accum_in = CODE_W'(b[4:0]);
            end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
               need_in  = 2'd2;
               class_in = CLASS_THREE;
               accum_in = CODE_W'(b[3:0]);
            end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
               need_in  = 2'd3;
               class_in = CLASS_FOUR;
               accum_in = CODE_W'(b[2:0]);
            end else begin
               bad_in = 1'b1;
            end
         end else if ((b & CONT_MASK) != CONT_CODE) begin
            bad_in   = 1'b1;
            need_in  = 2'd0;
            accum_in = '0;
            class_in = CLASS_NONE;
         end else begin
            need_in  = need_ff - 2'd1;
            accum_in = code_new;
            if (need_ff == 2'd1) begin
               if (code_new < code_low || code_new > CODE_MAX ||
                   (code_new >= SURR_LO && code_new <= SURR_HI)) begin
                  bad_in = 1'b1;
               end
               accum_in = '0;
               class_in = CLASS_NONE;
            end
         end

         // Line-ending normalization: CR LF and lone CR both become LF.
         if (cr_ff) begin
            cr_in = 1'b0;
            if (b == CHAR_LF) begin
               flags_in[1] = 1'b1;
               drop        = 1'b1;
            end else begin
               flags_in[2] = 1'b1;
            end
         end
         if (!drop) begin
            out_load = 1'b1;
            if (b == CHAR_CR) begin
               cr_in       = 1'b1;
               out_byte_in = CHAR_LF;
            end else if (b == CHAR_LF) begin
               flags_in[0] = 1'b1;
            end
            if (count_ff != LEN_MAX) begin
               count_in = count_ff + LEN_W'(1);
            end
         end
      end else if (fire) begin
         // Closing summary; the body state returns to its reset values.
         out_load    = 1'b1;
         out_kind_in = KIND_SUMMARY;
         out_byte_in = '0;
         out_mark_in = op_in.mark;
         out_len_in  = count_ff;
         if (op_in.oversize) begin
            out_status_in = STATUS_TOO_LARGE;
         end else if (fin_bad) begin
            out_status_in = STATUS_INVALID;
         end
         if ($countones(fin_flags) > 1) begin
            out_eol_in = EOL_MIXED;
         end else if (fin_flags[1]) begin
            out_eol_in = EOL_CRLF;
         end else if (fin_flags[2]) begin
            out_eol_in = EOL_CR;
         end
         need_in  = 2'd0;
         accum_in = '0;
         class_in = CLASS_NONE;
         bad_in   = 1'b0;
         cr_in    = 1'b0;
         flags_in = '0;
         count_in = '0;
      end
   end

   // Body state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         need_ff  <= 2'd0;
         accum_ff <= '0;
         class_ff <= CLASS_NONE;
         bad_ff   <= 1'b0;
         cr_ff    <= 1'b0;
         flags_ff <= '0;
         count_ff <= '0;
      end else begin
         need_ff  <= need_in;
         accum_ff <= accum_in;
         class_ff <= class_in;
         bad_ff   <= bad_in;
         cr_ff    <= cr_in;
         flags_ff <= flags_in;
         count_ff <= count_in;
      end
   end

   // Result register; it loads whenever the consumer side can take a result.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (op_ready) begin
         out_valid_ff <= out_load;
      end
      if (op_ready && out_load) begin
         out_kind_ff   <= out_kind_in;
         out_byte_ff   <= out_byte_in;
         out_last_ff   <= op_in.run_end;
         out_status_ff <= out_status_in;
         out_eol_ff    <= out_eol_in;
         out_mark_ff   <= out_mark_in;
         out_len_ff    <= out_len_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_FIELD_W){1'b0}}, out_len_ff, out_mark_ff,
                        out_eol_ff, out_status_ff, out_byte_ff};

endmodule

/* rtl/core/text_load_decoder.sv */
// Top level of the text load decoder: mark detection, work register and body checker.
`timescale 1ns / 1ps

// The decoder takes the bytes of one file on the req_ stream, the final byte
// marked by req_tlast, and returns the normalized text bytes on the rsp_ stream,
// followed by one summary transaction (rsp_tuser high) that carries status,
// line-ending kind, mark flag and text length; rsp_tlast marks the final
// result caused by each input byte. A leading EF BB BF mark is removed. One
// byte is taken per cycle while the output is not stalled and no held byte or
// summary is pending. The body checker handles one byte or one summary per
// cycle while its output register can take a result; held mark-candidate bytes
// (at most two, only at the start of a file) go before the byte that releases
// them, and a file's final byte is followed by its summary. Results are held
// in an output register; while one waits, a byte is taken only if no step is pending.
module text_load_decoder
   import tld_pkg::*;
#(
   parameter int unsigned MAX_FILE_BYTES = MAX_FILE_BYTES_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // req_tdata: data_byte[7:0]
   input  logic [BYTE_W-1:0]     req_tdata,
   // req_tlast: last_byte
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rsp_tdata: text_byte[7:0], status[9:8], eol_kind[11:10], had_mark[12],
   // text_length[36:13], zero fill[39:37]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: item_kind[0]
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   localparam logic [1:0]       START_DONE = 2'd3;
   localparam logic [LEN_W-1:0] SIZE_LIMIT = LEN_W'(MAX_FILE_BYTES);

   // Front state: mark detection and input byte count.
   logic [1:0]       start_ff, start_in;
   logic             mark_ff, mark_in;
   logic [LEN_W-1:0] in_count_ff, in_count_in;
   logic             over_ff, over_in;

   // Work register: the steps still to do for the accepted byte.
   logic              job_valid_ff;
   logic [1:0]        held_ff;
   logic              cur_ff;
   logic              sum_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic              job_mark_ff;
   logic              job_over_ff;

   logic [1:0]  held_new;
   logic        cur_new;
   logic [1:0]  held_rem;
   logic        cur_rem;
   logic        sum_rem;
   logic        last_step;
   logic        accept;
   logic        step;
   logic        op_ready;
   logic        match;
   logic [BYTE_W-1:0] mark_byte;
   op_type      op;

   assign accept = req_tvalid && req_tready;

   // Expected mark byte at the current start position.
   always_comb begin
      case (start_ff)
         2'd0:    mark_byte = MARK_B0;
         2'd1:    mark_byte = MARK_B1;
         default: mark_byte = MARK_B2;
      endcase
   end

   assign match = (req_tdata == mark_byte);

   // Decide what an accepted byte does to the mark detector and the size count.
   always_comb begin
      start_in    = start_ff;
      mark_in     = mark_ff;
      in_count_in = in_count_ff;
      over_in     = over_ff;
      held_new    = 2'b00;
      cur_new     = 1'b0;

      if (in_count_ff >= SIZE_LIMIT) begin
         over_in = 1'b1;
      end else begin
         in_count_in = in_count_ff + LEN_W'(1);
      end

      if (start_ff != START_DONE) begin
         if (match && start_ff == 2'd2) begin
            mark_in  = 1'b1;
            start_in = START_DONE;
         end else if (match && !req_tlast) begin
            start_in = start_ff + 2'd1;
         end else begin
            held_new = {start_ff == 2'd2, start_ff != 2'd0};
            start_in = START_DONE;
            cur_new  = 1'b1;
         end
      end else begin
         cur_new = 1'b1;
      end
   end

   // Front state registers; the end of a file returns them to reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff    <= 2'd0;
         mark_ff     <= 1'b0;
         in_count_ff <= '0;
         over_ff     <= 1'b0;
      end else if (accept) begin
         if (req_tlast) begin
            start_ff    <= 2'd0;
            mark_ff     <= 1'b0;
            in_count_ff <= '0;
            over_ff     <= 1'b0;
         end else begin
            start_ff    <= start_in;
            mark_ff     <= mark_in;
            in_count_ff <= in_count_in;
            over_ff     <= over_in;
         end
      end
   end

   // Steps left after the current one: held bytes, then the byte, then the summary.
   always_comb begin
      held_rem = held_ff;
      cur_rem  = cur_ff;
      sum_rem  = sum_ff;
      if (held_ff[0]) begin
         held_rem[0] = 1'b0;
      end else if (held_ff[1]) begin
         held_rem[1] = 1'b0;
      end else if (cur_ff) begin
         cur_rem = 1'b0;
      end else begin
         sum_rem = 1'b0;
      end
   end

   assign last_step = !(|held_rem) && !cur_rem && !sum_rem;

   // Current step handed to the body checker.
   always_comb begin
      op.valid    = job_valid_ff;
      op.summary  = !(|held_ff) && !cur_ff;
      op.data     = held_ff[0] ? MARK_B0 : (held_ff[1] ? MARK_B1 : byte_ff);
      op.mark     = job_mark_ff;
      op.oversize = job_over_ff;
      op.run_end  = last_step;
   end

   assign step       = job_valid_ff && op_ready;
   assign req_tready = !job_valid_ff || (op_ready && last_step);

   // Work register.
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else if (accept) begin
         job_valid_ff <= (|held_new) || cur_new || req_tlast;
      end else if (step) begin
         job_valid_ff <= !last_step;
      end
      if (accept) begin
         held_ff     <= held_new;
         cur_ff      <= cur_new;
         sum_ff      <= req_tlast;
         byte_ff     <= req_tdata;
         job_mark_ff <= mark_in;
         job_over_ff <= over_in;
      end else if (step) begin
         held_ff <= held_rem;
         cur_ff  <= cur_rem;
         sum_ff  <= sum_rem;
      end
   end

   tld_body u_body (
      .clock      (clock),
      .reset      (reset),
      .op_in      (op),
      .op_ready   (op_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* tb/text_load_decoder_tb.sv */
// Self-checking testbench of the text load decoder, with its own byte-level predictor.
`timescale 1ns / 1ps

// Bytes of whole files are streamed into the decoder, and every result is
// compared with a predictor kept in this module. A short table of directed
// files comes first: a stripped mark, a mark cut short at the end, CR LF
// handling, a NUL and a run of malformed sequences. Random files follow:
// mostly well-formed UTF-8 with random content, some with one fault, some
// noise and some pieces of a mark. Both handshakes stall at random, and the
// consumer holds off once for a long stretch.
module text_load_decoder_tb
   import tld_pkg::*;
();

   // Size limit of one file, in bytes, given to the block.
   localparam int unsigned SIZE_LIMIT = 1024;
   localparam int DIR_ROWS = 25;
   localparam int RANDOM_ITEMS = 145;
   localparam int LONG_HOLD = 400;
   localparam int SETTLE_CYCLES = 8;

   // One result transaction, field by field.
   typedef struct {
      kind_type          kind;
      logic [BYTE_W-1:0] text;
      logic              run_end;
      status_type        status;
      eol_type           eol;
      logic              mark;
      logic [LEN_W-1:0]  len;
   } text_result_type;

   // One row of the directed table; typed rows carry the summary they close with.
   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              typed;
      status_type        status;
      eol_type           eol;
      logic              mark;
      logic [LEN_W-1:0]  len;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   // Predictor state.
   logic [1:0]        mark_pos;
   logic [15:0]       mark_held;
   logic              cr_pending;
   logic [1:0]        cont_left;
   logic [CODE_W-1:0] code_point;
   logic [1:0]        seq_class;
   logic              enc_bad;
   logic [2:0]        eol_seen;
   logic              mark_found;
   logic [LEN_W-1:0]  bytes_in;
   logic [LEN_W-1:0]  bytes_out;
   logic              too_big;

   text_result_type step_results[$];
   text_result_type awaited_results[$];
   logic [BYTE_W-1:0] file_buf[$];

   int  errors = 0;
   int  results_checked = 0;
   int  bytes_sent = 0;
   int  files_sent = 0;
   bit  sender_burst = 0;
   bit  in_random = 0;
   bit  long_hold_done = 0;
   bit  mid_drain_done = 0;

   dir_row_type dir_rows[DIR_ROWS] = '{
      // Mark stripped, then a CR that ends the file.
      '{8'hEF, 1'b0, 1'b0, STATUS_OK, EOL_LF, 1'b0, 24'd0},
      '{8'hBB, 1'b0, 1'b0, STATUS_OK, EOL_LF, 1'b0, 24'd0},
      '{8'hBF, 1'b0, 1'b0, STATUS_OK, EOL_LF, 1'b0, 24'd0},
      '{8'h41, 1'b0, 1'b0, STATUS_OK, EOL_LF, 1'b0, 24'd0},
      '{8'h0D, 1'b1, 1'b1, STATUS_OK, EOL_CR, 1'b1, 24'd2},
      // File ends inside the mark: held bytes come out and the file is truncated.
      '{8'hEF, 1'b0, 1'b0, STATUS_OK, EOL_LF, 1'b0, 24'd0},
      '{8'hBB, 1'b1, 1'b1, STATUS_INVALID, EOL_LF, 1'b0, 24'd2},
      // CR LF with a dropped LF, then a plain LF: mixed endings.
      '{8'h0D, 1'b0, 1'b0, STATUS_OK, EOL_LF, 1'b0, 24'd0},
      '{8'h0A, 1'b0, 1'b0, STATUS_OK, EOL_LF, 1'b0, 24'd0},
      '{8'h0A, 1'b0, 1'b0, STATUS_OK, EOL_LF, 1'b0, 24'd0},
      '{8'h7F, 1'b1, 1'b1, STATUS_OK, EOL_MIXED, 1'b0, 24'd3},
      // A lone NUL.
      '{8'h00, 1'b1, 1'b1, STATUS_INVALID, EOL_LF, 1'b0, 24'd1},
      // Overlong, surrogate, above range, bad lead, bad continuation, truncated.
      '{8'hC0, 1'b0, 1'b0, STATUS_OK, EOL_LF, 1'b0, 24'd0},
      '{8'h80, 1'b0, 1'b0, STATUS_OK, EOL_LF, 1'b0, 24'd0},
      '{8'hED, 1'b0, 1'b0, STATUS_OK, EOL_LF, 1'b0, 24'd0},
      '{8'hA0, 1'b0, 1'b0, STATUS_OK, EOL_LF, 1'b0, 24'd0},
      '{8'h80, 1'b0, 1'b0, STATUS_OK, EOL_LF, 1'b0, 24'd0},
      '{8'hF4, 1'b0, 1'b0, STATUS_OK, EOL_LF, 1'b0, 24'd0},
      '{8'h90, 1'b0, 1'b0, STATUS_OK, EOL_LF, 1'b0, 24'd0},
      '{8'h80, 1'b0, 1'b0, STATUS_OK, EOL_LF, 1'b0, 24'd0},
      '{8'h80, 1'b0, 1'b0, STATUS_OK, EOL_LF, 1'b0, 24'd0},
      '{8'hFF, 1'b0, 1'b0, STATUS_OK, EOL_LF, 1'b0, 24'd0},
      '{8'hC2, 1'b0, 1'b0, STATUS_OK, EOL_LF, 1'b0, 24'd0},
      '{8'h41, 1'b0, 1'b0, STATUS_OK, EOL_LF, 1'b0, 24'd0},
      '{8'hF0, 1'b1, 1'b1, STATUS_INVALID, EOL_LF, 1'b0, 24'd13}
   };

   text_load_decoder #(
      .MAX_FILE_BYTES(SIZE_LIMIT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The run is cut off if it hangs.
   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   // Return the predictor to its state after reset or after a file.
   function automatic void clear_model();
      mark_pos = 2'd0;
      mark_held = 16'h0000;
      cr_pending = 1'b0;
      cont_left = 2'd0;
      code_point = '0;
      seq_class = 2'd0;
      enc_bad = 1'b0;
      eol_seen = 3'b000;
      mark_found = 1'b0;
      bytes_in = '0;
      bytes_out = '0;
      too_big = 1'b0;
   endfunction

   // Track one byte through the UTF-8 checker.
   function automatic void check_utf8(input logic [BYTE_W-1:0] b);
      logic [CODE_W-1:0] floor_cp;
      if (cont_left == 2'd0) begin
         if (b < 8'h80) begin
            if (b == CHAR_NUL) enc_bad = 1'b1;
         end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            cont_left = 2'd1;
            seq_class = 2'd1;
            code_point = CODE_W'(b[4:0]);
         end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            cont_left = 2'd2;
            seq_class = 2'd2;
            code_point = CODE_W'(b[3:0]);
         end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            cont_left = 2'd3;
            seq_class = 2'd3;
            code_point = CODE_W'(b[2:0]);
         end else begin
            enc_bad = 1'b1;
         end
      end else if ((b & CONT_MASK) != CONT_CODE) begin
         // A broken sequence is dropped, and the byte is not looked at again.
         enc_bad = 1'b1;
         cont_left = 2'd0;
         code_point = '0;
         seq_class = 2'd0;
      end else begin
         code_point = {code_point[14:0], b[5:0]};
         cont_left = cont_left - 2'd1;
         if (cont_left == 2'd0) begin
            floor_cp = (seq_class == 2'd1) ? MIN_TWO :
                       (seq_class == 2'd2) ? MIN_THREE : MIN_FOUR;
            if (code_point < floor_cp || code_point > CODE_MAX ||
                (code_point >= SURR_LO && code_point <= SURR_HI))
               enc_bad = 1'b1;
            code_point = '0;
            seq_class = 2'd0;
         end
      end
   endfunction

   // Queue one normalized text byte.
   function automatic void emit_text(input logic [BYTE_W-1:0] b);
      step_results.push_back('{KIND_TEXT, b, 1'b0, STATUS_OK, EOL_LF, 1'b0, '0});
      if (bytes_out != LEN_MAX) bytes_out = bytes_out + LEN_W'(1);
   endfunction

   // A byte of the body: checked, then passed on with line endings folded to LF.
   function automatic void take_text(input logic [BYTE_W-1:0] b);
      check_utf8(b);
      if (cr_pending) begin
         cr_pending = 1'b0;
         if (b == CHAR_LF) begin
            eol_seen[1] = 1'b1;
            return;
         end
         eol_seen[2] = 1'b1;
      end
      if (b == CHAR_CR) begin
         cr_pending = 1'b1;
         emit_text(CHAR_LF);
      end else begin
         if (b == CHAR_LF) eol_seen[0] = 1'b1;
         emit_text(b);
      end
   endfunction

   // Work out every result that one accepted input byte causes.
   function automatic void normalize_byte(input logic [BYTE_W-1:0] b, input logic last);
      logic [BYTE_W-1:0] mark_byte;
      eol_type           eol;
      status_type        st;
      step_results.delete();
      if (bytes_in >= SIZE_LIMIT) too_big = 1'b1;
      else bytes_in = bytes_in + LEN_W'(1);

      // Mark detection over the first three bytes.
      if (mark_pos < 2'd3) begin
         mark_byte = (mark_pos == 2'd0) ? MARK_B0 : (mark_pos == 2'd1) ? MARK_B1 : MARK_B2;
         if (b == mark_byte && mark_pos == 2'd2) begin
            mark_found = 1'b1;
            mark_pos = 2'd3;
            mark_held = 16'h0000;
         end else if (b == mark_byte && !last) begin
            mark_held[8*mark_pos +: 8] = b;
            mark_pos = mark_pos + 2'd1;
         end else begin
            for (int i = 0; i < mark_pos && i < 2; i++)
               take_text(mark_held[8*i +: 8]);
            mark_held = 16'h0000;
            mark_pos = 2'd3;
            take_text(b);
         end
      end else begin
         take_text(b);
      end

      // Closing summary.
      if (last) begin
         if (cr_pending) begin
            eol_seen[2] = 1'b1;
            cr_pending = 1'b0;
         end
         if (cont_left != 2'd0) enc_bad = 1'b1;
         eol = ($countones(eol_seen) > 1) ? EOL_MIXED :
               eol_seen[1] ? EOL_CRLF : eol_seen[2] ? EOL_CR : EOL_LF;
         st = too_big ? STATUS_TOO_LARGE : enc_bad ? STATUS_INVALID : STATUS_OK;
         step_results.push_back('{KIND_SUMMARY, 8'h00, 1'b0, st, eol, mark_found, bytes_out});
         clear_model();
      end
      if (step_results.size() > 0) step_results[step_results.size()-1].run_end = 1'b1;
   endfunction

   // Idle length: mostly none, sometimes short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // Append one well-formed character.
   function automatic void add_char();
      logic [CODE_W-1:0] cp;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: file_buf.push_back(BYTE_W'($urandom_range(1, 127)));
         4: file_buf.push_back(CHAR_LF);
         5: file_buf.push_back(CHAR_CR);
         6: begin
            file_buf.push_back(CHAR_CR);
            file_buf.push_back(CHAR_LF);
         end
         7: begin
            cp = CODE_W'($urandom_range(21'h80, 21'h7FF));
            file_buf.push_back({3'b110, cp[10:6]});
            file_buf.push_back({2'b10, cp[5:0]});
         end
         8: begin
            cp = CODE_W'($urandom_range(21'h800, 21'hFFFF));
            // Move surrogates up by 2000h, out of the surrogate range.
            if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 21'h2000;
            file_buf.push_back({4'b1110, cp[15:12]});
            file_buf.push_back({2'b10, cp[11:6]});
            file_buf.push_back({2'b10, cp[5:0]});
         end
         default: begin
            cp = CODE_W'($urandom_range(21'h10000, 21'h10FFFF));
            file_buf.push_back({5'b11110, cp[20:18]});
            file_buf.push_back({2'b10, cp[17:12]});
            file_buf.push_back({2'b10, cp[11:6]});
            file_buf.push_back({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   // Build one random file in file_buf.
   function automatic void build_random_file();
      int pick;
      file_buf.delete();
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         // Well-formed text, sometimes with one fault put in.
         if ($urandom_range(0, 1)) begin
            file_buf.push_back(MARK_B0);
            file_buf.push_back(MARK_B1);
            file_buf.push_back(MARK_B2);
         end
         repeat ($urandom_range(1, 10)) add_char();
         if (pick >= 55) begin
            case ($urandom_range(0, 4))
               0: file_buf[$urandom_range(0, file_buf.size()-1)] =
                     BYTE_W'($urandom_range(0, 255));
               1: if (file_buf.size() > 1) void'(file_buf.pop_back());
               2: file_buf.insert($urandom_range(0, file_buf.size()),
                                  BYTE_W'($urandom_range(8'h80, 8'hBF)));
               3: begin
                  // Overlong two- or three-byte form.
                  if ($urandom_range(0, 1)) begin
                     file_buf.push_back(BYTE_W'($urandom_range(8'hC0, 8'hC1)));
                     file_buf.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
                  end else begin
                     file_buf.push_back(8'hE0);
                     file_buf.push_back(BYTE_W'($urandom_range(8'h80, 8'h9F)));
                     file_buf.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
                  end
               end
               default: begin
                  // Surrogate, or a value past the top of the range.
                  if ($urandom_range(0, 1)) begin
                     file_buf.push_back(8'hED);
                     file_buf.push_back(BYTE_W'($urandom_range(8'hA0, 8'hBF)));
                     file_buf.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
                  end else begin
                     file_buf.push_back(BYTE_W'($urandom_range(8'hF4, 8'hF7)));
                     file_buf.push_back(BYTE_W'($urandom_range(8'h90, 8'hBF)));
                     file_buf.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
                     file_buf.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
                  end
               end
            endcase
         end
      end else if (pick < 88) begin
         repeat ($urandom_range(1, 8)) file_buf.push_back(BYTE_W'($urandom_range(0, 255)));
      end else begin
         // Pieces of a mark, whole or broken off.
         file_buf.push_back(MARK_B0);
         case ($urandom_range(0, 3))
            0: ;
            1: file_buf.push_back(MARK_B1);
            2: file_buf.push_back(BYTE_W'($urandom_range(0, 255)));
            default: begin
               file_buf.push_back(MARK_B1);
               file_buf.push_back(BYTE_W'($urandom_range(0, 255)));
            end
         endcase
         if ($urandom_range(0, 1)) add_char();
      end
   endfunction

   // Offer one byte, wait for its transaction, and predict its results.
   task automatic send_item(input logic [BYTE_W-1:0] d, input logic last);
      int gap;
      gap = sender_burst ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      normalize_byte(d, last);
      foreach (step_results[i]) awaited_results.push_back(step_results[i]);
      bytes_sent++;
   endtask

   // Send the file held in file_buf, the final byte marked.
   task automatic send_file();
      sender_burst = ($urandom_range(0, 99) < 20);
      foreach (file_buf[i]) send_item(file_buf[i], i == file_buf.size() - 1);
      files_sent++;
   endtask

   // Stop offering until every expected result has come out.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (awaited_results.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Compare one field of a result.
   function automatic void compare_field(input string name, input logic [LEN_W-1:0] want,
                                         input logic [LEN_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   // Check one accepted result against the oldest expectation.
   task automatic check_result();
      text_result_type want;
      if (awaited_results.size() == 0) begin
         $display("%0t: result with none expected, expected nothing, %s %h %b %b",
                  $time, "actual tdata, tuser, tlast", rsp_tdata, rsp_tuser, rsp_tlast);
         errors++;
         return;
      end
      want = awaited_results.pop_front();
      compare_field("item_kind", LEN_W'(want.kind), LEN_W'(rsp_tuser));
      compare_field("text_byte", LEN_W'(want.text), LEN_W'(rsp_tdata[7:0]));
      compare_field("run_end", LEN_W'(want.run_end), LEN_W'(rsp_tlast));
      compare_field("status", LEN_W'(want.status), LEN_W'(rsp_tdata[9:8]));
      compare_field("eol_kind", LEN_W'(want.eol), LEN_W'(rsp_tdata[11:10]));
      compare_field("had_mark", LEN_W'(want.mark), LEN_W'(rsp_tdata[12]));
      compare_field("text_length", want.len, rsp_tdata[36:13]);
      compare_field("zero fill", '0, LEN_W'(rsp_tdata[39:37]));
      results_checked++;
   endtask

   // Consumer: checks results and stalls at random, once for a long stretch.
   initial begin : consumer
      int stall_left;
      int calm_left;
      int r;
      stall_left = 0;
      calm_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_result();
         if (in_random && !long_hold_done && stall_left == 0) begin
            stall_left = LONG_HOLD;
            long_hold_done = 1;
         end else if (stall_left == 0 && calm_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 3) calm_left = $urandom_range(40, 120);
            else if (r < 20) stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (calm_left > 0) calm_left--;
            rsp_tready <= 1'b1;
         end
      end
   end

   // Producer: reset, directed table, then random files.
   initial begin : producer
      int last_idx;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      clear_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table; typed rows replace the predicted summary with the known one.
      foreach (dir_rows[i]) begin
         send_item(dir_rows[i].data, dir_rows[i].last);
         if (dir_rows[i].last) files_sent++;
         if (dir_rows[i].typed) begin
            last_idx = awaited_results.size() - 1;
            awaited_results[last_idx].status = dir_rows[i].status;
            awaited_results[last_idx].eol = dir_rows[i].eol;
            awaited_results[last_idx].mark = dir_rows[i].mark;
            awaited_results[last_idx].len = dir_rows[i].len;
         end
      end
      drain_results();

      // Random files; the consumer's long hold starts with them.
      in_random = 1;
      while (bytes_sent < DIR_ROWS + RANDOM_ITEMS) begin
         if (long_hold_done && !mid_drain_done && bytes_sent > DIR_ROWS + RANDOM_ITEMS / 2) begin
            drain_results();
            mid_drain_done = 1;
         end
         build_random_file();
         send_file();
      end

      drain_results();
      $display("Sent %0d files, %0d bytes in all; %0d results were compared.",
               files_sent, bytes_sent, results_checked);
      $display("Covered mark handling, line-ending folding and malformed UTF-8 under stalls.");
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
